>>> rtl/hla_pkg.sv
`default_nettype none
package hla_pkg;

   // Accumulator geometry
   localparam int NUM_ANGLES     = 180;
   localparam int MAX_DIM        = 512;
   localparam int RHO_BINS       = 727;
   localparam int COUNT_BITS     = 16;
   localparam int TRIG_FRAC_BITS = 14;

   localparam int NUM_CELLS   = NUM_ANGLES * RHO_BINS;
   localparam int ADDR_W      = $clog2(NUM_CELLS);
   localparam int ANGLE_W     = 8;
   localparam int RHO_IDX_W   = 10;
   localparam int COORD_W     = 9;
   localparam int DIM_W       = 10;
   localparam int RHO_MAX_W   = 9;
   localparam int PIXEL_W     = 8;
   localparam int MODE_W      = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 10;
   localparam int DELTA_W     = COORD_W + 1;
   localparam int QUARTER_N   = 91;
   localparam int QIDX_W      = 7;
   localparam int TRIG_W      = TRIG_FRAC_BITS + 1;
   localparam int COEF_W      = TRIG_W + 1;
   localparam int PROD_W      = DELTA_W + COEF_W;
   localparam int SUM_W       = PROD_W + 1;
   localparam int RHO_W       = SUM_W - TRIG_FRAC_BITS;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};
   localparam logic [PIXEL_W-1:0]    EDGE_PIXEL = 8'd255;

   // Request modes
   localparam logic [MODE_W-1:0] MODE_VOTE  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RHO_MAX      = 2'd2;

   localparam logic [DIM_W-1:0]     WIDTH_RESET   = 10'd512;
   localparam logic [DIM_W-1:0]     HEIGHT_RESET  = 10'd512;
   localparam logic [RHO_MAX_W-1:0] RHO_MAX_RESET = 9'd362;

   typedef enum logic [1:0] {
      OP_VOTE  = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   // Classified request passed from front to back
   typedef struct packed {
      op_type              op;
      logic [DELTA_W-1:0]  dx;
      logic [DELTA_W-1:0]  dy;
      logic [ADDR_W-1:0]   read_addr;
      logic                read_zero;
   } cmd_type;

   typedef logic [QUARTER_N-1:0][TRIG_W-1:0] sine_tab_type;

   localparam logic [63:0] PI_Q40 = 64'h3243F6A8886;

   // Q40 multiply with split operand, as the table generator does it
   function automatic logic [63:0] mul_q40(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] lo;
      logic [63:0] hi;
      lo = b & 64'hFFFFF;
      hi = b >> 20;
      return (a * hi + ((a * lo) >> 20)) >> 20;
   endfunction

   // Quarter-wave sine table, evaluated at elaboration
   function automatic sine_tab_type build_sine_table();
      sine_tab_type tab;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  term;
      logic [63:0]  sum;
      logic [63:0]  rnd;
      for (int k = 0; k < QUARTER_N; k++) begin
         x    = (PI_Q40 * 64'(k) + 64'd90) / 64'd180;
         x2   = mul_q40(x, x);
         term = x;
         sum  = x;
         for (int n = 1; n <= 8; n++) begin
            term = mul_q40(term, x2) / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         rnd    = (sum + (64'd1 << (39 - TRIG_FRAC_BITS))) >> (40 - TRIG_FRAC_BITS);
         tab[k] = rnd[TRIG_W-1:0];
      end
      return tab;
   endfunction

   localparam sine_tab_type SINE_TABLE = build_sine_table();

endpackage
`default_nettype wire

>>> rtl/hla_front.sv
`default_nettype none
module hla_front import hla_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [MODE_W-1:0]     req_mode,
   input  wire logic [COORD_W-1:0]    req_x_coord,
   input  wire logic [COORD_W-1:0]    req_y_coord,
   input  wire logic [PIXEL_W-1:0]    req_pixel_value,
   input  wire logic [ANGLE_W-1:0]    req_angle_index,
   input  wire logic [RHO_IDX_W-1:0]  req_rho_index,
   input  wire logic [DIM_W-1:0]      image_width,
   input  wire logic [DIM_W-1:0]      image_height,
   input  wire logic                  init_done,
   input  wire logic                  q_full,
   output logic                       q_push,
   output cmd_type                    q_cmd
);

   logic [DIM_W-1:0]   w_cap;
   logic [DIM_W-1:0]   h_cap;
   logic [DIM_W-1:0]   w_half;
   logic [DIM_W-1:0]   h_half;
   logic               in_image;
   logic               keep;
   logic [ADDR_W-1:0]  row_addr;

   // Hold off requests until the reset clearing pass is over and while the queue is full
   assign req_ready = init_done && !q_full;

   // Cap the image size and center the pixel
   always_comb begin
      w_cap    = (image_width  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : image_width;
      h_cap    = (image_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : image_height;
      w_half   = w_cap >> 1;
      h_half   = h_cap >> 1;
      in_image = ({1'b0, req_x_coord} < w_cap) && ({1'b0, req_y_coord} < h_cap);
      row_addr = ADDR_W'(req_angle_index) * ADDR_W'(RHO_BINS);
   end

   // Classify the request; drop those with no effect
   always_comb begin
      q_cmd.op        = OP_VOTE;
      q_cmd.dx        = {1'b0, req_x_coord} - w_half;
      q_cmd.dy        = {1'b0, req_y_coord} - h_half;
      q_cmd.read_addr = row_addr + ADDR_W'(req_rho_index);
      q_cmd.read_zero = (req_angle_index >= ANGLE_W'(NUM_ANGLES)) ||
                        (req_rho_index >= RHO_IDX_W'(RHO_BINS));
      keep            = 1'b0;
      case (req_mode)
         MODE_VOTE: begin
            q_cmd.op = OP_VOTE;
            keep     = (req_pixel_value == EDGE_PIXEL) && in_image;
         end
         MODE_READ: begin
            q_cmd.op = OP_READ;
            keep     = 1'b1;
         end
         MODE_CLEAR: begin
            q_cmd.op = OP_CLEAR;
            keep     = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
      q_push = req_valid && req_ready && keep;
   end

   // No request may enter before the clearing pass ends
   a_no_accept_during_init: assert property (@(posedge clock) disable iff (reset)
      !init_done |-> !q_push)
      else $error("request taken during clearing pass");

   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full && req_valid)
      else $error("push into full queue");

   a_vote_in_image: assert property (@(posedge clock) disable iff (reset)
      (q_push && q_cmd.op == OP_VOTE) |-> in_image && req_pixel_value == EDGE_PIXEL)
      else $error("vote outside image queued");

endmodule
`default_nettype wire

>>> rtl/hla_queue.sv
`default_nettype none
module hla_queue import hla_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         full,
   input  wire logic    pop,
   output logic         valid,
   output cmd_type      pop_cmd
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type             slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff;
   logic [PTR_W-1:0]    wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff;
   logic [PTR_W-1:0]    rd_ptr_in;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;

   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign valid   = (count_ff != '0);
   assign pop_cmd = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed requests
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push || pop)
      else $error("queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> valid)
      else $error("queue underflow");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("occupancy lost a push");

endmodule
`default_nettype wire

>>> rtl/hla_back.sv
`default_nettype none
module hla_back import hla_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   q_valid,
   input  wire cmd_type                q_cmd,
   output logic                        q_pop,
   input  wire logic [RHO_MAX_W-1:0]   rho_max,
   output logic                        init_done,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [COUNT_BITS-1:0]       rsp_vote_count
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CLEAR = 6'b000010,
      ST_VOTE  = 6'b000100,
      ST_DRAIN = 6'b001000,
      ST_READ  = 6'b010000,
      ST_RESP  = 6'b100000
   } state_type;

   state_type                  state_ff;
   state_type                  state_in;
   logic                       init_done_ff;
   logic                       init_done_in;
   logic [ADDR_W-1:0]          clr_cnt_ff;
   logic [ADDR_W-1:0]          clr_cnt_in;
   logic [ANGLE_W-1:0]         angle_ff;
   logic [ANGLE_W-1:0]         angle_in;
   logic [ADDR_W-1:0]          base_ff;
   logic [ADDR_W-1:0]          base_in;
   logic [DELTA_W-1:0]         dx_ff;
   logic [DELTA_W-1:0]         dy_ff;
   logic [ADDR_W-1:0]          read_addr_ff;
   logic                       read_zero_ff;
   logic                       load_cmd;

   // Vote pipeline
   logic [ANGLE_W-1:0]         sin_idx_w;
   logic [ANGLE_W-1:0]         cos_idx_w;
   logic                       cos_neg;
   logic signed [COEF_W-1:0]   sin_coef;
   logic signed [COEF_W-1:0]   cos_coef;
   logic signed [PROD_W-1:0]   pcos_ff;
   logic signed [PROD_W-1:0]   psin_ff;
   logic [ADDR_W-1:0]          base_s1_ff;
   logic                       v1_ff;
   logic signed [SUM_W-1:0]    sum_s2;
   logic signed [RHO_W-1:0]    rho_s2;
   logic signed [RHO_W-1:0]    col_s2;
   logic                       col_ok;
   logic [ADDR_W-1:0]          addr_s2_ff;
   logic                       v2_ff;
   logic [ADDR_W-1:0]          addr_s3_ff;
   logic                       v3_ff;

   // Accumulator memory ports
   logic [COUNT_BITS-1:0]      acc_mem [NUM_CELLS];
   logic                       rd_en;
   logic [ADDR_W-1:0]          rd_addr;
   logic [COUNT_BITS-1:0]      rd_data_ff;
   logic                       wr_en;
   logic [ADDR_W-1:0]          wr_addr;
   logic [COUNT_BITS-1:0]      wr_data;

   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic [COUNT_BITS-1:0]      rsp_count_ff;
   logic                       rsp_load;

   assign init_done      = init_done_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_vote_count = rsp_count_ff;
   assign q_pop          = (state_ff == ST_IDLE) && q_valid;
   assign load_cmd       = q_pop;
   assign rsp_load       = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_ready);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      init_done_in = init_done_ff;
      clr_cnt_in   = clr_cnt_ff;
      angle_in     = angle_ff;
      base_in      = base_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               case (q_cmd.op)
                  OP_VOTE: begin
                     angle_in = '0;
                     base_in  = '0;
                     state_in = ST_VOTE;
                  end
                  OP_READ: begin
                     state_in = ST_READ;
                  end
                  OP_CLEAR: begin
                     clr_cnt_in = '0;
                     state_in   = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            if (clr_cnt_ff == ADDR_W'(NUM_CELLS - 1)) begin
               init_done_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end
         ST_VOTE: begin
            angle_in = angle_ff + 1'b1;
            base_in  = base_ff + ADDR_W'(RHO_BINS);
            if (angle_ff == ANGLE_W'(NUM_ANGLES - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!v1_ff && !v2_ff && !v3_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         init_done_ff <= 1'b0;
         clr_cnt_ff   <= '0;
         angle_ff     <= '0;
         base_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         init_done_ff <= init_done_in;
         clr_cnt_ff   <= clr_cnt_in;
         angle_ff     <= angle_in;
         base_ff      <= base_in;
      end
   end

   // Latch the popped request
   always_ff @(posedge clock) begin
      if (load_cmd) begin
         dx_ff        <= q_cmd.dx;
         dy_ff        <= q_cmd.dy;
         read_addr_ff <= q_cmd.read_addr;
         read_zero_ff <= q_cmd.read_zero;
      end
   end

   // Fold the angle onto the quarter-wave table
   always_comb begin
      if (angle_ff <= ANGLE_W'(90)) begin
         sin_idx_w = angle_ff;
         cos_idx_w = ANGLE_W'(90) - angle_ff;
         cos_neg   = 1'b0;
      end else begin
         sin_idx_w = ANGLE_W'(180) - angle_ff;
         cos_idx_w = angle_ff - ANGLE_W'(90);
         cos_neg   = 1'b1;
      end
      sin_coef = $signed({1'b0, SINE_TABLE[sin_idx_w[QIDX_W-1:0]]});
      cos_coef = cos_neg ? -$signed({1'b0, SINE_TABLE[cos_idx_w[QIDX_W-1:0]]})
                         :  $signed({1'b0, SINE_TABLE[cos_idx_w[QIDX_W-1:0]]});
   end

   // Stage 1: products
   always_ff @(posedge clock) begin
      pcos_ff    <= $signed(dx_ff) * cos_coef;
      psin_ff    <= $signed(dy_ff) * sin_coef;
      base_s1_ff <= base_ff;
   end

   // Stage 2: round rho half up, offset to a column, range check
   always_comb begin
      sum_s2 = SUM_W'(pcos_ff) + SUM_W'(psin_ff) + SUM_W'(1 << (TRIG_FRAC_BITS - 1));
      rho_s2 = sum_s2[SUM_W-1:TRIG_FRAC_BITS];
      col_s2 = rho_s2 + $signed(RHO_W'(rho_max));
      col_ok = !col_s2[RHO_W-1] &&
               ($unsigned(col_s2) <= (RHO_W'(rho_max) << 1)) &&
               ($unsigned(col_s2) <  RHO_W'(RHO_BINS));
   end

   always_ff @(posedge clock) begin
      addr_s2_ff <= base_s1_ff + ADDR_W'($unsigned(col_s2));
      addr_s3_ff <= addr_s2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= (state_ff == ST_VOTE);
         v2_ff <= v1_ff && col_ok;
         v3_ff <= v2_ff;
      end
   end

   // Memory read port: vote pipeline or cell read
   always_comb begin
      rd_en   = v2_ff || (state_ff == ST_READ);
      rd_addr = (state_ff == ST_READ) ? read_addr_ff : addr_s2_ff;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= acc_mem[rd_addr];
      end
   end

   // Memory write port: saturating increment or clear
   always_comb begin
      wr_en   = v3_ff || (state_ff == ST_CLEAR);
      wr_addr = (state_ff == ST_CLEAR) ? clr_cnt_ff : addr_s3_ff;
      if (state_ff == ST_CLEAR) begin
         wr_data = '0;
      end else if (rd_data_ff == COUNT_MAX) begin
         wr_data = rd_data_ff;
      end else begin
         wr_data = rd_data_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         acc_mem[wr_addr] <= wr_data;
      end
   end

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_count_ff <= read_zero_ff ? '0 : rd_data_ff;
      end
   end

   a_clear_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !v3_ff && !v2_ff)
      else $error("vote write during clear");

   a_read_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ || state_ff == ST_RESP) |-> !v1_ff && !v2_ff && !v3_ff)
      else $error("cell read before votes retired");

   a_angle_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_VOTE) |-> angle_ff < ANGLE_W'(NUM_ANGLES))
      else $error("angle counter out of range");

   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESP))
      else $error("response without a read");

endmodule
`default_nettype wire

>>> rtl/hough_line_accumulator_unit.sv
`default_nettype none
// Hough line accumulator: 180 angle rows by 727 rho columns of 16-bit
// saturating counts in one on-chip memory with one read and one write
// port. A vote request (mode 0) with pixel value 255 inside the image
// adds one to at most one cell in each angle row; the memory takes one
// read-modify-write per cycle, so a vote occupies the back end while it
// is taken from the queue, steps through the 180 angles and the pipeline
// drains. A read request (mode 1) returns one response; a read outside
// the array returns 0. A clear request (mode 2) sweeps the memory one
// cell per cycle, and after reset the same sweep runs before req_ready
// first rises. Votes, clears, mode 3 and non-edge pixels give no
// response. A two-entry queue lets requests be taken while the back end
// is busy. Registers: 0 image width, 1 image height, 2 rho_max; write
// them only while the block is idle.
module hough_line_accumulator_unit import hla_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [MODE_W-1:0]     req_mode,
   input  wire logic [COORD_W-1:0]    req_x_coord,
   input  wire logic [COORD_W-1:0]    req_y_coord,
   input  wire logic [PIXEL_W-1:0]    req_pixel_value,
   input  wire logic [ANGLE_W-1:0]    req_angle_index,
   input  wire logic [RHO_IDX_W-1:0]  req_rho_index,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [COUNT_BITS-1:0]      rsp_vote_count,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data
);

   logic [DIM_W-1:0]      width_ff;
   logic [DIM_W-1:0]      height_ff;
   logic [RHO_MAX_W-1:0]  rho_max_ff;
   logic                  init_done;
   logic                  q_full;
   logic                  q_push;
   cmd_type               push_cmd;
   logic                  q_pop;
   logic                  q_valid;
   cmd_type               pop_cmd;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WIDTH_RESET;
         height_ff  <= HEIGHT_RESET;
         rho_max_ff <= RHO_MAX_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff   <= csr_write_data[DIM_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff  <= csr_write_data[DIM_W-1:0];
            CSR_RHO_MAX:      rho_max_ff <= csr_write_data[RHO_MAX_W-1:0];
            default: begin
            end
         endcase
      end
   end

   hla_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_x_coord     (req_x_coord),
      .req_y_coord     (req_y_coord),
      .req_pixel_value (req_pixel_value),
      .req_angle_index (req_angle_index),
      .req_rho_index   (req_rho_index),
      .image_width     (width_ff),
      .image_height    (height_ff),
      .init_done       (init_done),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_cmd           (push_cmd)
   );

   hla_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .pop_cmd  (pop_cmd)
   );

   hla_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_cmd          (pop_cmd),
      .q_pop          (q_pop),
      .rho_max        (rho_max_ff),
      .init_done      (init_done),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_vote_count (rsp_vote_count)
   );

endmodule
`default_nettype wire
